// File: design/lwfc_pkg.sv
`default_nettype none

package lwfc_pkg;

  localparam int TrigFracBitsDef = 14;

  localparam int RangeW = 16;
  localparam int TrigW  = 16;
  localparam int SpeedW = 12;
  localparam int TurnW  = 13;

  localparam int GapW = 17;
  localparam logic [GapW-1:0] GapNone = '1;

  // shared multiplier operand and product widths
  localparam int MulW  = 25;
  localparam int ProdW = 2 * MulW;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 12;

  localparam logic [CfgIdxW-1:0] CfgFollowLeft  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgLaserOffset = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgFrontLength = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgHalfWidth   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgFrontMargin = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgSideTarget  = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgMaxSpeed    = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgMaxTurn     = 3'd7;

  // exact floor division of values below 2^22 by 1000 and 10000
  localparam logic [MulW-1:0] Recip1000  = 25'd4294968;
  localparam logic [MulW-1:0] Recip10000 = 25'd6871948;
  localparam int Shift1000  = 32;
  localparam int Shift10000 = 36;

  localparam logic [9:0] MeetExtra = 10'd111;
  localparam logic [9:0] SpeedCap  = 10'd1000;
  localparam logic [9:0] TurnClamp = 10'd1000;

  typedef struct packed {
    logic        follow_left;
    logic [9:0]  laser_offset;
    logic [10:0] fwd_limit;
    logic [9:0]  body_half;
    logic [8:0]  front_margin;
    logic [9:0]  wall_gap;
    logic [11:0] max_speed;
    logic [11:0] max_turn;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    follow_left:  1'b0,
    laser_offset: 10'd290,
    fwd_limit:    11'd300,
    body_half:    10'd200,
    front_margin: 9'd50,
    wall_gap:     10'd100,
    max_speed:    12'd800,
    max_turn:     12'd500
  };

  typedef struct packed {
    logic            front_hit;
    logic            side_hit;
    logic [GapW-1:0] gap;
  } zone_t;

endpackage

`default_nettype wire

// File: design/lwfc_mul.sv
`default_nettype none

module lwfc_mul import lwfc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [MulW-1:0]  a_i,
  input  logic signed [MulW-1:0]  b_i,
  output logic signed [ProdW-1:0] p_o
);

  logic signed [ProdW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= ProdW'(a_i) * ProdW'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// File: design/lwfc_zone.sv
`default_nettype none

module lwfc_zone import lwfc_pkg::*; #(
  parameter int CoordW = 21
) (
  input  logic signed [CoordW-1:0] x_i,
  input  logic signed [CoordW-1:0] y_i,
  input  cfg_t                     cfg_i,
  output zone_t                    zone_o
);

  localparam int ZW = (CoordW + 2 > GapW + 2) ? CoordW + 2 : GapW + 2;

  logic signed [ZW-1:0] xs, ys, ay;
  logic signed [ZW-1:0] fl, hw, lat_lim, gap_lim;
  logic signed [ZW-1:0] front_gap, right_gap, left_gap, sel_gap;
  logic                 front_hit, right_hit, left_hit;

  assign xs      = ZW'(x_i);
  assign ys      = ZW'(y_i);
  assign ay      = (ys < 0) ? -ys : ys;
  assign fl      = ZW'(cfg_i.fwd_limit);
  assign hw      = ZW'(cfg_i.body_half);
  assign lat_lim = ZW'(cfg_i.body_half) + ZW'(cfg_i.front_margin);
  assign gap_lim = ZW'(GapNone);

  assign front_gap = xs - fl;
  assign right_gap = -ys - hw;
  assign left_gap  = ys - hw;

  assign front_hit = (xs > fl) && (ay < lat_lim);
  assign right_hit = !cfg_i.follow_left && (xs < fl) && (ys < -hw);
  assign left_hit  = cfg_i.follow_left && (xs < fl) && (ys > hw);

  always_comb begin
    if (front_hit) begin
      sel_gap = front_gap;
    end else if (cfg_i.follow_left) begin
      sel_gap = left_gap;
    end else begin
      sel_gap = right_gap;
    end
  end

  // selected gap is always positive when its zone hits
  assign zone_o.front_hit = front_hit;
  assign zone_o.side_hit  = !front_hit && (right_hit || left_hit);
  assign zone_o.gap       = (sel_gap > gap_lim) ? GapNone : sel_gap[GapW-1:0];

endmodule

`default_nettype wire

// File: design/lidar_wall_follow_controller.sv
`default_nettype none

// Wall-follow controller fed by a stream of laser beams and control ticks.
// Input channel (in_valid_i/in_ready_o): kind_i 0 is a beam with range and
// Q-format cosine/sine plus first/last-of-scan marks, kind_i 1 is a tick.
// Beams produce no output; they update running minima of the front gap and
// the followed-side gap, cleared at the first beam and committed at the last.
// Each tick produces one beat on the output channel (out_valid_o/out_ready_i)
// with linear speed, turn rate and the meet/leave flags.
// Flow: in_ready_o is high only when the sequencer is idle, so an item is
// taken only after the previous one is done. The single 25x25 multiplier
// is used twice per beam (x and y projection, then capture and gap update)
// and four times per tick (speed product, divide by reciprocal, turn
// product, divide by reciprocal, then output hand-off). The result sits in
// an output register; beams are still taken while it waits, and a
// following tick holds in its last step until the register frees. Reset
// is immediate: registers return to defaults, held gaps read as far away,
// leave state clears. The user must make config writes only while idle;
// the block itself does not enforce this.

module lidar_wall_follow_controller import lwfc_pkg::*; #(
  parameter int TrigFracBits = TrigFracBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_idx_i,
  input  logic [CfgDataW-1:0]       cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      kind_i,
  input  logic [RangeW-1:0]         range_mm_i,
  input  logic signed [TrigW-1:0]   beam_cos_i,
  input  logic signed [TrigW-1:0]   beam_sin_i,
  input  logic                      first_beam_i,
  input  logic                      last_beam_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [SpeedW-1:0]         linear_speed_o,
  output logic signed [TurnW-1:0]   turn_rate_o,
  output logic                      meet_flag_o,
  output logic                      leave_flag_o
);

  localparam int CoordW = 35 - TrigFracBits;
  localparam logic signed [ProdW-1:0] RoundHalf = ProdW'(64'sd1 << (TrigFracBits - 1));

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StBx   = 4'd1;
  localparam logic [3:0] StBy   = 4'd2;
  localparam logic [3:0] StBcap = 4'd3;
  localparam logic [3:0] StBupd = 4'd4;
  localparam logic [3:0] StT0   = 4'd5;
  localparam logic [3:0] StT1   = 4'd6;
  localparam logic [3:0] StT2   = 4'd7;
  localparam logic [3:0] StT3   = 4'd8;
  localparam logic [3:0] StT4   = 4'd9;
  localparam logic [3:0] StT5   = 4'd10;

  logic [3:0] state_q, state_d;
  cfg_t       cfg_q;

  logic [GapW-1:0] run_front_q, run_side_q, held_front_q, held_side_q;
  logic [GapW-1:0] run_front_d, run_side_d, front_base, side_base;
  logic            leave_q;

  logic                     out_valid_q;
  logic [SpeedW-1:0]        speed_out_q;
  logic signed [TurnW-1:0]  turn_out_q;
  logic                     meet_out_q, leave_out_q;

  logic [RangeW-1:0]        range_q;
  logic signed [TrigW-1:0]  cos_q, sin_q;
  logic                     first_q, last_q;
  logic signed [CoordW-1:0] x_q, y_q;

  logic                     meet_q, slow_q, neg_q;
  logic [9:0]               f_q, dmag_q;
  logic [SpeedW-1:0]        speed_q;

  logic                     mul_en;
  logic signed [MulW-1:0]   mul_a, mul_b;
  logic signed [ProdW-1:0]  mul_p;
  logic signed [ProdW-1:0]  rnd_full;

  logic                     in_fire, out_free;
  zone_t                    zone;

  // tick front-end
  logic                     meet_c, leave_c;
  logic signed [17:0]       delta, delta_c;
  logic [9:0]               f_c, dmag_c;
  logic [SpeedW-1:0]        turn_mag;
  logic signed [TurnW-1:0]  turn_c;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  lwfc_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  lwfc_zone #(
    .CoordW (CoordW)
  ) u_zone (
    .x_i    (x_q),
    .y_i    (y_q),
    .cfg_i  (cfg_q),
    .zone_o (zone)
  );

  // round half up: floor((p + half) / 2^F)
  assign rnd_full = (mul_p + RoundHalf) >>> TrigFracBits;

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      StBx: begin
        mul_a = MulW'({1'b0, range_q});
        mul_b = MulW'(cos_q);
      end
      StBy: begin
        mul_a = MulW'({1'b0, range_q});
        mul_b = MulW'(sin_q);
      end
      StT1: begin
        mul_a = MulW'(f_q);
        mul_b = MulW'(cfg_q.max_speed);
      end
      StT2: begin
        mul_a = mul_p[MulW-1:0];
        mul_b = slow_q ? Recip10000 : Recip1000;
      end
      StT3: begin
        mul_a = MulW'(dmag_q);
        mul_b = MulW'(cfg_q.max_turn);
      end
      StT4: begin
        mul_a = mul_p[MulW-1:0];
        mul_b = Recip1000;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    front_base  = first_q ? GapNone : run_front_q;
    side_base   = first_q ? GapNone : run_side_q;
    run_front_d = (zone.front_hit && (zone.gap < front_base)) ? zone.gap : front_base;
    run_side_d  = (zone.side_hit && (zone.gap < side_base)) ? zone.gap : side_base;
  end

  always_comb begin
    meet_c = held_front_q < GapW'({1'b0, cfg_q.wall_gap} + {1'b0, MeetExtra});
    f_c    = (held_front_q > GapW'(SpeedCap)) ? SpeedCap : held_front_q[9:0];
    delta  = signed'({1'b0, held_side_q}) - signed'(18'(cfg_q.wall_gap));
    leave_c = delta > signed'(18'({cfg_q.wall_gap, 1'b0}));
    if (delta > signed'(18'(TurnClamp))) begin
      delta_c = 18'(TurnClamp);
    end else if (delta < -signed'(18'(TurnClamp))) begin
      delta_c = -signed'(18'(TurnClamp));
    end else begin
      delta_c = delta;
    end
    dmag_c = (delta_c < 0) ? 10'(-delta_c) : delta_c[9:0];
  end

  assign turn_mag = mul_p[Shift1000 +: SpeedW];

  always_comb begin
    if (meet_q) begin
      turn_c = cfg_q.follow_left ? -signed'({1'b0, cfg_q.max_turn})
                                 : signed'({1'b0, cfg_q.max_turn});
    end else begin
      turn_c = neg_q ? -signed'({1'b0, turn_mag}) : signed'({1'b0, turn_mag});
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = kind_i ? StT0 : StBx;
        end
      end
      StBx:   state_d = StBy;
      StBy:   state_d = StBcap;
      StBcap: state_d = StBupd;
      StBupd: state_d = StIdle;
      StT0:   state_d = StT1;
      StT1:   state_d = StT2;
      StT2:   state_d = StT3;
      StT3:   state_d = StT4;
      StT4:   state_d = StT5;
      StT5: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cfg_q        <= CfgReset;
      run_front_q  <= GapNone;
      run_side_q   <= GapNone;
      held_front_q <= GapNone;
      held_side_q  <= GapNone;
      leave_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgFollowLeft:  cfg_q.follow_left  <= cfg_data_i[0];
          CfgLaserOffset: cfg_q.laser_offset <= cfg_data_i[9:0];
          CfgFrontLength: cfg_q.fwd_limit    <= cfg_data_i[10:0];
          CfgHalfWidth:   cfg_q.body_half    <= cfg_data_i[9:0];
          CfgFrontMargin: cfg_q.front_margin <= cfg_data_i[8:0];
          CfgSideTarget:  cfg_q.wall_gap     <= cfg_data_i[9:0];
          CfgMaxSpeed:    cfg_q.max_speed    <= cfg_data_i[11:0];
          CfgMaxTurn:     cfg_q.max_turn     <= cfg_data_i[11:0];
          default: ;
        endcase
      end
      if (state_q == StBupd) begin
        run_front_q <= run_front_d;
        run_side_q  <= run_side_d;
        if (last_q) begin
          held_front_q <= run_front_d;
          held_side_q  <= run_side_d;
        end
      end
      if (state_q == StT0) begin
        leave_q <= leave_c;
      end
      if (state_q == StT5 && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      range_q <= range_mm_i;
      cos_q   <= beam_cos_i;
      sin_q   <= beam_sin_i;
      first_q <= first_beam_i;
      last_q  <= last_beam_i;
    end
    if (state_q == StBy) begin
      x_q <= rnd_full[CoordW-1:0] + CoordW'(cfg_q.laser_offset);
    end
    if (state_q == StBcap) begin
      y_q <= rnd_full[CoordW-1:0];
    end
    if (state_q == StT0) begin
      meet_q <= meet_c;
      slow_q <= meet_c || leave_q;
      f_q    <= f_c;
      dmag_q <= dmag_c;
      // turn sign: delta sign, flipped when following the right wall
      neg_q  <= (delta_c < 0) ^ !cfg_q.follow_left;
    end
    if (state_q == StT3) begin
      speed_q <= slow_q ? mul_p[Shift10000 +: SpeedW] : mul_p[Shift1000 +: SpeedW];
    end
    if (state_q == StT5 && out_free) begin
      speed_out_q <= speed_q;
      turn_out_q  <= turn_c;
      meet_out_q  <= meet_q;
      leave_out_q <= leave_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign linear_speed_o = speed_out_q;
  assign turn_rate_o    = turn_out_q;
  assign meet_flag_o    = meet_out_q;
  assign leave_flag_o   = leave_out_q;

endmodule

`default_nettype wire

// File: design/lwfc_checker.sv
`default_nettype none

module lwfc_checker import lwfc_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [SpeedW-1:0]        linear_speed_o,
  input logic signed [TurnW-1:0]  turn_rate_o,
  input logic                     meet_flag_o,
  input logic                     leave_flag_o
);

  // result beat is held while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(linear_speed_o) && $stable(turn_rate_o)
      && $stable(meet_flag_o) && $stable(leave_flag_o))
    else $error("output payload changed while stalled");

  // an accepted item keeps the sequencer busy in the cycle after it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken on consecutive cycles");

  // a result only appears at the end of a busy sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result produced while idle");

  // meeting an obstacle uses the reduced speed scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && meet_flag_o |-> linear_speed_o <= 12'd409)
    else $error("full speed while meeting an obstacle");

endmodule

bind lidar_wall_follow_controller lwfc_checker u_lwfc_checker (.*);

`default_nettype wire
